/* rtl/positional_list_insert_remove_assert.svh */
// ---------------------------------------------------------------------------
// positional_list_insert_remove_assert.svh
// Assertion macros for the positional list RTL.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pil_pkg.sv */
// ---------------------------------------------------------------------------
// pil_pkg
// Widths, codes and defaults for the positional list.
// ---------------------------------------------------------------------------
`default_nettype none

package pil_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam action_t ACT_READ   = 3'd0;
  localparam action_t ACT_INSERT = 3'd1;
  localparam action_t ACT_REMOVE = 3'd2;
  localparam action_t ACT_COUNT  = 3'd3;
  localparam action_t ACT_DUMP   = 3'd4;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_EMPTY  = 3'd1;
  localparam status_t ST_FULL   = 3'd2;
  localparam status_t ST_BADPOS = 3'd3;
  localparam status_t ST_NOELEM = 3'd4;

endpackage

`default_nettype wire

/* rtl/positional_list_insert_remove.sv */
// ---------------------------------------------------------------------------
// positional_list_insert_remove
// Ordered list of signed words in a single-port-write, registered-read
// memory, with read, insert, remove, count and dump requests by position.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in_      | input     | in_valid / in_stall     | action, position, value
//  out_     | output    | out_valid / out_stall   | status, data, slot, last
//
//  One request is worked on at a time; in_stall is low only while idle.
//  Errors, count and append reach the registered result through S_RESP, a
//  read through S_READ, and removing the last entry through S_REM_CAP and
//  S_RESP. Any other remove and an insert in the middle move the entries one
//  at a time in S_SHIFT and S_DRAIN; an insert then writes its value in
//  S_PUT. The memory's single read and single write port set this.
//  A dump gives one result per cycle while the output is not stalled.
//  Reset is synchronous; the memory is not cleared. Output stalls hold the
//  result register while the next request may already be taken.
`default_nettype none

module positional_list_insert_remove #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [pil_pkg::ACT_W-1:0]  in_action,
  input  wire logic        [pil_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [pil_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [pil_pkg::STAT_W-1:0] out_status,
  output logic signed      [pil_pkg::DATA_W-1:0] out_data,
  output logic             [pil_pkg::POS_W-1:0]  out_slot,
  output logic                                   out_last
);

`include "positional_list_insert_remove_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_READ    = 8'b0000_0010,
    S_REM_CAP = 8'b0000_0100,
    S_SHIFT   = 8'b0000_1000,
    S_DRAIN   = 8'b0001_0000,
    S_PUT     = 8'b0010_0000,
    S_RESP    = 8'b0100_0000,
    S_DUMP    = 8'b1000_0000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [pil_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic signed [pil_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]                  src_r, src_nxt;
  logic [AW-1:0]                  prev_r, prev_nxt;
  logic [AW-1:0]                  end_r, end_nxt;
  logic                           up_r, up_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  pil_pkg::status_t               res_status_r, res_status_nxt;
  logic signed [pil_pkg::DATA_W-1:0] res_data_r, res_data_nxt;
  logic [pil_pkg::POS_W-1:0]      res_slot_r, res_slot_nxt;

  logic                           out_valid_r, out_valid_nxt;
  pil_pkg::status_t               out_status_r, out_status_nxt;
  logic signed [pil_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic [pil_pkg::POS_W-1:0]      out_slot_r, out_slot_nxt;
  logic                           out_last_r, out_last_nxt;

  logic signed [pil_pkg::DATA_W-1:0] mem [CAPACITY];
  logic signed [pil_pkg::DATA_W-1:0] rdata_r;
  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_wa, mem_ra;
  logic signed [pil_pkg::DATA_W-1:0] mem_wd;

  logic [XW-1:0] in_pos_x, pos_x, count_x;
  logic [CW-1:0] idx_inc;
  logic          in_acc, out_free, is_empty, is_full, in_bad, in_beyond, dump_last;
  logic          ins_grow;

  assign in_pos_x  = XW'(in_position);
  assign pos_x     = XW'(pos_r);
  assign count_x   = XW'(count_r);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r >= CW'(CAPACITY));
  assign in_bad    = (in_pos_x == '0) || (in_pos_x > XW'(CAPACITY));
  assign in_beyond = (in_pos_x > count_x);
  assign idx_inc   = CW'(idx_r) + 1'b1;
  assign dump_last = (idx_inc == count_r);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign ins_grow = in_acc && (in_action == pil_pkg::ACT_INSERT) && !is_full && !in_bad;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    src_nxt        = src_r;
    prev_nxt       = prev_r;
    end_nxt        = end_r;
    up_nxt         = up_r;
    rd_vld_nxt     = rd_vld_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt        = in_position;
          val_nxt        = in_value;
          res_status_nxt = pil_pkg::ST_OK;
          res_data_nxt   = '0;
          res_slot_nxt   = '0;
          case (in_action)
            pil_pkg::ACT_READ, pil_pkg::ACT_REMOVE: begin
              if (is_empty) begin
                res_status_nxt = pil_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else if (in_bad) begin
                res_status_nxt = pil_pkg::ST_BADPOS;
                state_nxt      = S_RESP;
              end else if (in_beyond) begin
                res_status_nxt = pil_pkg::ST_NOELEM;
                state_nxt      = S_RESP;
              end else begin
                mem_re = 1'b1;
                mem_ra = AW'(in_pos_x - 1'b1);
                if (in_action == pil_pkg::ACT_READ) begin
                  state_nxt = S_READ;
                end else begin
                  count_nxt    = count_r - 1'b1;
                  res_slot_nxt = in_position;
                  state_nxt    = S_REM_CAP;
                end
              end
            end
            pil_pkg::ACT_INSERT: begin
              if (is_full) begin
                res_status_nxt = pil_pkg::ST_FULL;
                state_nxt      = S_RESP;
              end else if (in_bad) begin
                res_status_nxt = pil_pkg::ST_BADPOS;
                state_nxt      = S_RESP;
              end else begin
                count_nxt    = count_r + 1'b1;
                res_data_nxt = in_value;
                if (in_beyond) begin
                  // Position past the end: append at the first free entry.
                  mem_we       = 1'b1;
                  mem_wa       = AW'(count_r);
                  mem_wd       = in_value;
                  res_slot_nxt = pil_pkg::POS_W'(count_x + 1'b1);
                  state_nxt    = S_RESP;
                end else begin
                  src_nxt      = AW'(count_r - 1'b1);
                  end_nxt      = AW'(in_pos_x - 1'b1);
                  up_nxt       = 1'b1;
                  rd_vld_nxt   = 1'b0;
                  res_slot_nxt = in_position;
                  state_nxt    = S_SHIFT;
                end
              end
            end
            pil_pkg::ACT_COUNT: begin
              if (is_empty) begin
                res_status_nxt = pil_pkg::ST_EMPTY;
              end else begin
                res_data_nxt = pil_pkg::DATA_W'(count_r);
              end
              state_nxt = S_RESP;
            end
            pil_pkg::ACT_DUMP: begin
              if (is_empty) begin
                res_status_nxt = pil_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pil_pkg::ST_OK;
          out_data_nxt   = rdata_r;
          out_slot_nxt   = pos_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_REM_CAP: begin
        // The count already excludes the removed entry, so entries from
        // pos up to the new count move down by one.
        res_data_nxt = rdata_r;
        if (pos_x > count_x) begin
          state_nxt = S_RESP;
        end else begin
          src_nxt    = AW'(pos_x);
          end_nxt    = AW'(count_r);
          up_nxt     = 1'b0;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Read one entry per cycle and write the previous one to its
        // neighbor; the write always trails the read away from it.
        mem_re = 1'b1;
        mem_ra = src_r;
        if (rd_vld_r) begin
          mem_we = 1'b1;
          mem_wa = up_r ? prev_r + 1'b1 : prev_r - 1'b1;
          mem_wd = rdata_r;
        end
        prev_nxt   = src_r;
        rd_vld_nxt = 1'b1;
        if (src_r == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          src_nxt = up_r ? src_r - 1'b1 : src_r + 1'b1;
        end
      end
      S_DRAIN: begin
        mem_we     = 1'b1;
        mem_wa     = up_r ? prev_r + 1'b1 : prev_r - 1'b1;
        mem_wd     = rdata_r;
        rd_vld_nxt = 1'b0;
        state_nxt  = up_r ? S_PUT : S_RESP;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(pos_x - 1'b1);
        mem_wd    = val_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_slot_nxt   = res_slot_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pil_pkg::ST_OK;
          out_data_nxt   = rdata_r;
          out_slot_nxt   = pil_pkg::POS_W'(idx_inc);
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = AW'(idx_inc);
            idx_nxt = AW'(idx_inc);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    src_r        <= src_nxt;
    prev_r       <= prev_nxt;
    end_r        <= end_nxt;
    up_r         <= up_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_slot   = out_slot_r;
  assign out_last   = out_last_r;

  `PIL_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(CAPACITY), "entry count above capacity")
  `PIL_ASSERT_NOW(a_no_rw_clash, mem_we && mem_re, mem_wa != mem_ra, "read and write clash")
  `PIL_ASSERT_NOW(a_dump_idx, state_r == S_DUMP, idx_inc <= count_r, "dump index past the count")
  `PIL_ASSERT_NEXT(a_ins_count, ins_grow, count_r == $past(count_r) + 1'b1, "count did not grow")

endmodule

`default_nettype wire
